/* src/tcw_pkg.sv */
// Shared constants and types of the text console writer.
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CELL_W  = 16;
    localparam int INDEX_W = 11;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

    localparam logic [7:0] CODE_NUL       = 8'h00;
    localparam logic [7:0] CODE_BACKSPACE = 8'h08;
    localparam logic [7:0] CODE_NEWLINE   = 8'h0A;
    localparam logic [7:0] CODE_SPACE     = 8'h20;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ADVANCE,
        CUR_BACK,
        CUR_NEWLINE,
        CUR_BOTTOM
    } cur_op_t;

    typedef struct packed {
        logic at_origin;
        logic at_last;
        logic on_bottom;
    } cur_status_t;

endpackage

/* src/text_console_writer.sv */
// Text console writer top level: sequencer, result registers, cell store and cursor.
//
// A character-cell screen of COLUMNS x ROWS cells, each holding attribute in the
// upper byte and character in the lower byte, with a write cursor. A request is
// taken at a rising edge where start is high and busy is low; func selects a put
// (interpret char_code with color) or a read of the cell at cell_index. Exactly one
// result follows each request: done is high for one cycle with cell_data, cursor and
// scrolled valid, and the receiver cannot hold it off, so it must capture it then.
// A put that does not scroll writes the cell as it is accepted and gives its result
// in the next cycle, staying idle for the next request; a read passes through the
// registered read port of the cell store and the S_READ state. A put that runs past
// the last cell, or a newline on the bottom row, scrolls the screen: a single address
// counter walks the store, reading each cell one row down and writing it back one
// row up, then fills the bottom row with blanks once the last copy write has left
// the port, as the store has one read and one write port. After reset busy stays
// high while the store is swept to blank cells. Reads at a cell_index past the
// screen return 0 and change nothing.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        func,
    input  logic [7:0]                  char_code,
    input  logic [7:0]                  color,
    input  logic [tcw_pkg::INDEX_W-1:0] cell_index,
    output logic                        done,
    output logic [tcw_pkg::CELL_W-1:0]  cell_data,
    output logic [tcw_pkg::INDEX_W-1:0] cursor,
    output logic                        scrolled
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_COPY,
        S_BLANK
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic              pend_reg, pend_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              done_reg, done_next;
    logic              scrolled_reg, scrolled_next;
    logic [CELL_W-1:0] cell_data_reg, cell_data_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [CELL_W-1:0] mem_wr_data;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [CELL_W-1:0] mem_rd_data;

    cur_op_t           cur_op;
    logic [ADDR_W-1:0] cur_lin;
    cur_status_t       cur_status;

    logic              accept;

    assign accept = start && (state_reg == S_IDLE);

    tcw_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (cur_op),
        .lin    (cur_lin),
        .status (cur_status)
    );

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        wr_addr_next   = wr_addr_reg;
        pend_next      = 1'b0;
        rd_ok_next     = rd_ok_reg;
        done_next      = 1'b0;
        scrolled_next  = scrolled_reg;
        cell_data_next = cell_data_reg;

        mem_we      = 1'b0;
        mem_wr_addr = sweep_reg;
        mem_wr_data = BLANK_CELL;
        mem_rd_addr = sweep_reg;
        cur_op      = CUR_HOLD;

        // A copy read issued last cycle is written back one row up now.
        if (pend_reg)
        begin
            mem_we      = 1'b1;
            mem_wr_addr = wr_addr_reg;
            mem_wr_data = mem_rd_data;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (sweep_reg == ADDR_W'(CELLS - 1))
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_READ)
                    begin
                        mem_rd_addr = ADDR_W'(cell_index);
                        rd_ok_next  = (32'(cell_index) < CELLS);
                        state_next  = S_READ;
                    end
                    else
                    begin
                        done_next      = 1'b1;
                        scrolled_next  = 1'b0;
                        cell_data_next = '0;
                        unique case (char_code)
                            CODE_NEWLINE:
                            begin
                                if (cur_status.on_bottom)
                                begin
                                    cur_op    = CUR_BOTTOM;
                                    done_next = 1'b0;
                                end
                                else
                                begin
                                    cur_op = CUR_NEWLINE;
                                end
                            end
                            CODE_BACKSPACE:
                            begin
                                if (!cur_status.at_origin)
                                begin
                                    mem_we      = 1'b1;
                                    mem_wr_addr = cur_lin - ADDR_W'(1);
                                    mem_wr_data = {color, CODE_SPACE};
                                    cur_op      = CUR_BACK;
                                end
                            end
                            CODE_NUL:
                            begin
                                cur_op = CUR_HOLD;
                            end
                            default:
                            begin
                                mem_we      = 1'b1;
                                mem_wr_addr = cur_lin;
                                mem_wr_data = {color, char_code};
                                if (cur_status.at_last)
                                begin
                                    cur_op    = CUR_BOTTOM;
                                    done_next = 1'b0;
                                end
                                else
                                begin
                                    cur_op = CUR_ADVANCE;
                                end
                            end
                        endcase
                        // A put that scrolls starts the copy from the second row.
                        if (!done_next)
                        begin
                            sweep_next = ADDR_W'(COLUMNS);
                            state_next = S_COPY;
                        end
                    end
                end
            end
            S_READ:
            begin
                done_next      = 1'b1;
                scrolled_next  = 1'b0;
                cell_data_next = rd_ok_reg ? mem_rd_data : '0;
                state_next     = S_IDLE;
            end
            S_COPY:
            begin
                pend_next    = 1'b1;
                wr_addr_next = sweep_reg - ADDR_W'(COLUMNS);
                if (sweep_reg == ADDR_W'(CELLS - 1))
                begin
                    sweep_next = ADDR_W'(CELLS - COLUMNS);
                    state_next = S_BLANK;
                end
                else
                begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end
            S_BLANK:
            begin
                // The last copy write takes the port first; blanking waits until it is done.
                if (!pend_reg)
                begin
                    mem_we = 1'b1;
                    if (sweep_reg == ADDR_W'(CELLS - 1))
                    begin
                        done_next      = 1'b1;
                        scrolled_next  = 1'b1;
                        cell_data_next = '0;
                        sweep_next     = '0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        sweep_next = sweep_reg + ADDR_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            sweep_reg    <= '0;
            pend_reg     <= 1'b0;
            rd_ok_reg    <= 1'b0;
            done_reg     <= 1'b0;
            scrolled_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            pend_reg     <= pend_next;
            rd_ok_reg    <= rd_ok_next;
            done_reg     <= done_next;
            scrolled_reg <= scrolled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg   <= wr_addr_next;
        cell_data_reg <= cell_data_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign cell_data = cell_data_reg;
    assign cursor    = INDEX_W'(cur_lin);
    assign scrolled  = scrolled_reg;

    // A result is only ever presented once the sequencer is back in idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result presented while the sequencer is busy");

    // After a scroll the cursor sits at the start of the bottom row.
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && scrolled_reg) |-> (cur_lin == ADDR_W'(CELLS - COLUMNS)))
        else $error("cursor not at the bottom row after a scroll");

    // Pending copy writes exist only during a scroll.
    a_pend_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_COPY || state_reg == S_BLANK))
        else $error("copy write pending outside a scroll");

    // The cursor never leaves the screen.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_lin) < CELLS)
        else $error("cursor beyond the last cell");

    // A read request yields its result, without the scrolled flag, after the S_READ state.
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == FUNC_READ) |=> ##1 (done_reg && !scrolled_reg))
        else $error("read result not delivered on time");

endmodule

/* src/tcw_ram.sv */
// Screen cell store: one write port and one registered read port.
module tcw_ram #(
    parameter int DEPTH  = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [tcw_pkg::CELL_W-1:0] rd_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/tcw_cursor.sv */
// Cursor tracker: keeps row, column and linear cell number in step.
module tcw_cursor #(
    parameter int  COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int  ROWS    = tcw_pkg::DEF_ROWS,
    localparam int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcw_pkg::cur_op_t     op,
    output logic [ADDR_W-1:0]    lin,
    output tcw_pkg::cur_status_t status
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] lin_reg, lin_next;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        lin_next = lin_reg;
        unique case (op)
            CUR_ADVANCE:
            begin
                if (col_reg == COL_W'(COLUMNS - 1))
                begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
                lin_next = lin_reg + ADDR_W'(1);
            end
            CUR_BACK:
            begin
                if (col_reg == '0)
                begin
                    col_next = COL_W'(COLUMNS - 1);
                    row_next = row_reg - ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg - COL_W'(1);
                end
                lin_next = lin_reg - ADDR_W'(1);
            end
            CUR_NEWLINE:
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
                lin_next = lin_reg - ADDR_W'(col_reg) + ADDR_W'(COLUMNS);
            end
            CUR_BOTTOM:
            begin
                col_next = '0;
                row_next = ROW_W'(ROWS - 1);
                lin_next = ADDR_W'(CELLS - COLUMNS);
            end
            default:
            begin
                col_next = col_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            lin_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            lin_reg <= lin_next;
        end
    end

    assign lin              = lin_reg;
    assign status.at_origin = (lin_reg == '0);
    assign status.at_last   = (lin_reg == ADDR_W'(CELLS - 1));
    assign status.on_bottom = (row_reg == ROW_W'(ROWS - 1));

    // The linear cell number must always agree with row and column.
    a_lin_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'(lin_reg) == 32'(row_reg) * COLUMNS + 32'(col_reg))
        else $error("cursor cell number out of step with row and column");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < COLUMNS)
        else $error("cursor column beyond the row");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(row_reg) < ROWS)
        else $error("cursor row beyond the screen");

endmodule
